// ----- hw/rtl/pid_controller_antiwindup_assert.svh -----
// Assertion macros for the PID controller block.
// Used by the top level; no other dependencies.
`ifndef PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH

// implication checked every edge outside reset
`define PID_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pid assertion failed");

// next-cycle implication
`define PID_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pid assertion failed");

`endif

// ----- hw/rtl/pid_pkg.sv -----
// Shared types and constants for the PID controller block.
// No dependencies.
package pid_pkg;
    localparam int OutMax = 25600;
    localparam int AccW   = 72;

    typedef enum logic [3:0] {
        ADDR_KP = 4'd0,
        ADDR_TI = 4'd4,
        ADDR_TD = 4'd8
    } addr_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MULP  = 9'b000000010,
        ST_INTA  = 9'b000000100,
        ST_DIVI  = 9'b000001000,
        ST_MULD  = 9'b000010000,
        ST_DIVD  = 9'b000100000,
        ST_SUM   = 9'b001000000,
        ST_OUT   = 9'b010000000,
        ST_CLAMP = 9'b100000000
    } state_t;
endpackage

// ----- hw/rtl/pid_controller_antiwindup.sv -----
// PID controller with integral clamp, bit-serial datapath.
// Depends on pid_pkg and pid_controller_antiwindup_assert.svh.
//
// One item at a time. The error is registered on acceptance, then Kp*error is
// formed by shift-add, the integral is updated and clamped, the
// integral division by Ti takes 64 restoring steps plus one to add it in,
// Td*delta takes 32 steps and the division by the time step 64 steps plus one;
// a zero time step skips the integral and derivative terms. A single
// shift-add / restoring subtract unit, one bit per cycle, does every step.
// The result sits in an output register; the next item is taken while that
// beat waits, and a finished result holds in the last step until it is free.
`include "pid_controller_antiwindup_assert.svh"
module pid_controller_antiwindup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [15:0] setpoint,
    input  logic signed [23:0] measurement,
    input  logic [19:0] time_step,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [14:0] drive_percent,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pid_pkg::*;

    logic [23:0] kp_reg;
    logic [31:0] ti_reg, td_reg;
    logic signed [63:0] integ_reg, integ_next;
    logic signed [25:0] perr_reg;
    state_t state_reg;
    logic [6:0]  cnt_reg;
    logic signed [25:0] err_reg;
    logic [19:0] dt_reg;
    // serial unit: multiplicand/divisor, shifting operand, accumulator
    logic [63:0] opa_reg;
    logic [63:0] opb_reg;
    logic [64:0] acc_reg;
    logic        neg_reg;
    logic signed [AccW-1:0] sum_reg;
    logic [14:0] out_reg;
    logic        ovalid_reg;

    logic signed [26:0] dlt;
    logic signed [AccW-1:0] quot_s;
    logic [64:0] rem_try;
    logic signed [63:0] lim;
    logic signed [46:0] edt;
    logic signed [65:0] integ_sum;
    logic cfg_wr;
    logic out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = ovalid_reg;
    assign drive_percent = out_reg;
    assign out_free = !ovalid_reg || !out_stall;

    always_comb
    begin
        unique case (paddr)
            ADDR_KP: prdata = {8'd0, kp_reg};
            ADDR_TI: prdata = ti_reg;
            ADDR_TD: prdata = td_reg;
            default: prdata = 32'd0;
        endcase
    end

    assign dlt = 27'(err_reg) - 27'(perr_reg);
    assign lim = 64'(ti_reg) * 64'sd25600;
    assign rem_try = {acc_reg[63:0], opb_reg[63]} - {1'b0, opa_reg};
    assign quot_s = neg_reg ? -AccW'($signed({1'b0, opb_reg})) : AccW'($signed({1'b0, opb_reg}));
    assign edt = 47'(err_reg) * 47'($signed({1'b0, dt_reg}));
    assign integ_sum = 66'(integ_reg) + 66'(edt);

    always_comb
    begin
        integ_next = integ_reg;
        if (integ_sum > 66'(lim))
            integ_next = lim;
        else if (integ_sum < -66'(lim))
            integ_next = -lim;
        else
            integ_next = integ_sum[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= 24'd65536;
            ti_reg <= '0;
            td_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                ADDR_KP: kp_reg <= pwdata[23:0];
                ADDR_TI: ti_reg <= pwdata;
                ADDR_TD: td_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ovalid_reg <= 1'b0;
            integ_reg <= '0;
            perr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_CLAMP && out_free)
                ovalid_reg <= 1'b1;
            else if (!out_stall)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                if (in_valid && !in_stall)
                begin
                    err_reg <= 26'($signed({setpoint, 8'd0})) - 26'(measurement);
                    dt_reg <= time_step;
                    state_reg <= ST_MULP;
                    cnt_reg <= '0;
                    acc_reg <= '0;
                    opa_reg <= 64'(kp_reg);
                    begin
                        logic signed [25:0] e;
                        e = 26'($signed({setpoint, 8'd0})) - 26'(measurement);
                        neg_reg <= e[25];
                        opb_reg <= 64'(e[25] ? -e : e);
                    end
                end
                ST_MULP:
                begin
                    // shift-add, LSB first; then truncate /65536 toward zero
                    if (opb_reg[0])
                        acc_reg <= acc_reg + 65'(opa_reg);
                    opa_reg <= opa_reg << 1;
                    opb_reg <= opb_reg >> 1;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd25)
                        state_reg <= ST_INTA;
                end
                ST_INTA:
                begin
                    begin
                        logic [63:0] p;
                        p = (opb_reg[0] ? acc_reg[63:0] + opa_reg : acc_reg[63:0]) >> 16;
                        sum_reg <= neg_reg ? -AccW'($signed({1'b0, p})) : AccW'($signed({1'b0, p}));
                    end
                    if (dt_reg == 20'd0)
                        state_reg <= ST_CLAMP;
                    else if (ti_reg != 32'd0)
                    begin
                        integ_reg <= integ_next;
                        neg_reg <= integ_next[63];
                        opb_reg <= integ_next[63] ? -integ_next : integ_next;
                        opa_reg <= 64'(ti_reg);
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= ST_DIVI;
                    end
                    else
                        state_reg <= ST_MULD;
                    if (dt_reg != 20'd0 && ti_reg == 32'd0)
                    begin
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        neg_reg <= dlt[26];
                        opb_reg <= 64'(dlt[26] ? -dlt : dlt);
                        opa_reg <= 64'(td_reg);
                    end
                end
                ST_DIVI, ST_DIVD:
                begin
                    // restoring division, one quotient bit a cycle
                    if (!rem_try[64])
                    begin
                        acc_reg <= rem_try;
                        opb_reg <= {opb_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        acc_reg <= {acc_reg[63:0], opb_reg[63]};
                        opb_reg <= {opb_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63)
                        state_reg <= (state_reg == ST_DIVI) ? ST_SUM : ST_OUT;
                end
                ST_SUM:
                begin
                    sum_reg <= sum_reg + quot_s;
                    acc_reg <= '0;
                    cnt_reg <= '0;
                    neg_reg <= dlt[26];
                    opb_reg <= 64'(dlt[26] ? -dlt : dlt);
                    opa_reg <= 64'(td_reg);
                    state_reg <= ST_MULD;
                end
                ST_MULD:
                begin
                    if (td_reg == 32'd0)
                        state_reg <= ST_CLAMP;
                    else
                    begin
                        if (opb_reg[0])
                            acc_reg <= acc_reg + 65'(opa_reg);
                        opa_reg <= opa_reg << 1;
                        opb_reg <= opb_reg >> 1;
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cnt_reg == 7'd31)
                        begin
                            // product done: start dividing by dt
                            opb_reg <= opb_reg[0] ? acc_reg[63:0] + opa_reg : acc_reg[63:0];
                            opa_reg <= 64'(dt_reg);
                            acc_reg <= '0;
                            cnt_reg <= '0;
                            state_reg <= ST_DIVD;
                        end
                    end
                end
                ST_OUT:
                begin
                    sum_reg <= sum_reg + quot_s;
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP:
                begin
                    // hold here while the previous beat still waits
                    if (out_free)
                    begin
                        if (sum_reg < 0)
                            out_reg <= '0;
                        else if (sum_reg > AccW'(OutMax))
                            out_reg <= 15'(OutMax);
                        else
                            out_reg <= sum_reg[14:0];
                        if (dt_reg != 20'd0)
                            perr_reg <= err_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `PID_ASSERT_IMP(a_out_range, ovalid_reg, out_reg <= 15'(OutMax))
    `PID_ASSERT_IMP(a_busy_stall, state_reg != ST_IDLE, in_stall)
    `PID_ASSERT_NXT(a_clamp_valid, state_reg == ST_CLAMP && out_free, ovalid_reg && state_reg == ST_IDLE)
endmodule

// ----- tb/sv/pid_drive_checker.sv -----
// Checker for the PID controller: watches the input, output and register ports,
// predicts drive_percent for every accepted beat and compares. Depends on pid_pkg.
module pid_drive_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] setpoint,
    input  logic signed [23:0] measurement,
    input  logic [19:0]        time_step,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [14:0]        drive_percent,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pid_pkg::*;

    logic [23:0] kp_gain;
    logic [31:0] ti_secs;
    logic [31:0] td_secs;
    longint      integ_acc;
    longint      last_err;
    logic [14:0] drive_q[$];

    function automatic logic [14:0] clamp_drive(longint x);
        if (x < 0)
            return 15'd0;
        if (x > OutMax)
            return 15'(OutMax);
        return 15'(x);
    endfunction

    // updates the integral and last error state as a side effect
    function automatic logic [14:0] next_drive(logic signed [15:0] sp,
                                               logic signed [23:0] ms,
                                               logic [19:0] dt);
        longint err;
        longint sum;
        longint bound;
        longint ti;
        longint dtl;
        err = longint'(sp) * 256 - longint'(ms);
        sum = (longint'(kp_gain) * err) / 65536;
        dtl = longint'(dt);
        if (dt == 0)
            return clamp_drive(sum);
        if (ti_secs != 0) begin
            ti = longint'(ti_secs);
            bound = ti * 25600;
            integ_acc = integ_acc + err * dtl;
            if (integ_acc > bound)
                integ_acc = bound;
            else if (integ_acc < -bound)
                integ_acc = -bound;
            sum = sum + integ_acc / ti;
        end
        if (td_secs != 0)
            sum = sum + (longint'(td_secs) * (err - last_err)) / dtl;
        last_err = err;
        return clamp_drive(sum);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            kp_gain   <= 24'd65536;
            ti_secs   <= '0;
            td_secs   <= '0;
            integ_acc = 0;
            last_err  = 0;
            errors    <= 0;
            pending   <= 0;
            drive_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == 4'(ADDR_KP))
                    kp_gain <= pwdata[23:0];
                else if (paddr == 4'(ADDR_TI))
                    ti_secs <= pwdata;
                else if (paddr == 4'(ADDR_TD))
                    td_secs <= pwdata;
            end
            if (in_valid && !in_stall)
                drive_q.push_back(next_drive(setpoint, measurement, time_step));
            if (out_valid && !out_stall) begin
                if (drive_q.size() == 0) begin
                    $display("%0t: unexpected beat, drive_percent %0d", $time, drive_percent);
                    errors <= errors + 1;
                end else begin
                    if (drive_percent !== drive_q[0]) begin
                        $display("%0t: drive_percent expected %0d actual %0d",
                                 $time, drive_q[0], drive_percent);
                        errors <= errors + 1;
                    end
                    void'(drive_q.pop_front());
                end
            end
            pending <= drive_q.size();
        end
    end
endmodule

// ----- tb/sv/pid_controller_antiwindup_tb.sv -----
// Top of the PID controller testbench: clock, reset, register writes and beats.
// Depends on pid_pkg, pid_drive_checker and the pid_controller_antiwindup block.
module pid_controller_antiwindup_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pid_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] setpoint;
    logic signed [23:0] measurement;
    logic [19:0]        time_step;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [14:0]        drive_percent;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 errors;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_cycles = 0;
    logic               hold_taken = 1'b0;
    logic               hold_ask;
    int                 beats_sent;

    pid_controller_antiwindup dut (.*);

    pid_drive_checker chk (.*);

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver: random stall, or a long hold-off once requested
    always @(posedge clk) begin
        if (hold_ask && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_cycles <= 600;
            out_stall   <= 1'b1;
        end else if (hold_cycles > 0) begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic reg_write(logic [3:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_beat(logic signed [15:0] sp, logic signed [23:0] ms,
                             logic [19:0] dt);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        setpoint    <= sp;
        measurement <= ms;
        time_step   <= dt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // pause until every result is back, then allow for block latency
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic rand_beat();
        int sp;
        int ms;
        int dt;
        int pick;
        sp   = $urandom_range(65535) - 32768;
        pick = $urandom_range(99);
        if (pick < 15)
            ms = $urandom;
        else if (pick < 40)
            ms = sp * 256 + int'($urandom_range(4095)) - 2048;
        else
            ms = sp * 256 + int'($urandom_range(65535)) - 32768;
        pick = $urandom_range(99);
        if (pick < 10)
            dt = 0;
        else if (pick < 25)
            dt = $urandom_range(1048575);
        else
            dt = $urandom_range(8192, 1);
        send_beat(16'(sp), 24'(ms), 20'(dt));
    endtask

    initial begin
        logic [31:0] kp;
        logic [31:0] ti;
        logic [31:0] td;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        setpoint      = '0;
        measurement   = '0;
        time_step     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_ask      = 1'b0;
        beats_sent    = 0;
        send_idle_pct = 25;
        recv_idle_pct = 73;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: proportional only
        send_beat(16'sh7fff, 24'sh800000, 20'd0);
        send_beat(16'sh8000, 24'sh7fffff, 20'hfffff);
        send_beat(16'sd10, 24'sd0, 20'd1);
        send_beat(16'sd0, 24'sd2560, 20'd100);
        drain();

        reg_write(4'(ADDR_KP), 32'h00ffffff);
        reg_write(4'(ADDR_TI), 32'h00010000);
        reg_write(4'(ADDR_TD), 32'h00004000);
        reg_write(4'd12, 32'hffffffff);   // outside the map, ignored
        send_beat(16'sd1, 24'sd0, 20'd0);
        send_beat(16'sd1, 24'sd200, 20'd0);
        send_beat(16'sd50, 24'sd0, 20'd65536);
        send_beat(16'sd50, 24'sd0, 20'hfffff);  // integral pinned at the bound
        send_beat(-16'sd50, 24'sd0, 20'd1);     // large negative derivative
        send_beat(16'sd0, 24'sd0, 20'd0);
        drain();
        reg_write(4'(ADDR_KP), 32'h0);
        send_beat(16'sd3, 24'sd512, 20'd4096);
        drain();
        // shrink Ti: stored integral is used against the new bound next step
        reg_write(4'(ADDR_TI), 32'h00000100);
        send_beat(16'sd0, 24'sd0, 20'd0);
        send_beat(16'sd1, 24'sd0, 20'd16);
        drain();
        reg_write(4'(ADDR_TI), 32'h0);
        send_beat(16'sd1, 24'sd0, 20'd16);
        drain();
        reg_write(4'(ADDR_TI), 32'hffffffff);
        reg_write(4'(ADDR_TD), 32'hffffffff);
        send_beat(16'sh7fff, 24'sh800000, 20'd1);
        send_beat(16'sh8000, 24'sh7fffff, 20'd1);
        send_beat(16'sh8000, 24'sh7fffff, 20'hfffff);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            send_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 73 : 0;
            recv_idle_pct = (phase < 2) ? 73 : (phase < 4) ? 25 : 0;
            case (phase)
                0: begin kp = 32'h0; ti = 32'h0; td = 32'h0; end
                1: begin kp = 32'hffffff; ti = 32'hffffffff; td = 32'hffffffff; end
                default: begin
                    kp = $urandom_range(32'h40000);
                    ti = ($urandom_range(3) == 0) ? 32'h0 : $urandom_range(32'h100000, 32'h100);
                    td = ($urandom_range(3) == 0) ? 32'h0 : $urandom_range(32'h40000, 32'h10);
                end
            endcase
            reg_write(4'(ADDR_KP), kp);
            reg_write(4'(ADDR_TI), ti);
            reg_write(4'(ADDR_TD), td);
            for (int n = 0; n < 255; n++) begin
                if (phase == 2 && n == 20)
                    hold_ask <= 1'b1;
                rand_beat();
            end
            drain();
        end

        $display("Sent %0d beats: directed corners, then six gain phases incl. all-zero, all-max,",
                 beats_sent);
        $display("with stalls on both sides, a long output hold-off and full drains.");
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
